/* design/sfi_pkg.sv */
`default_nettype none
package sfi_pkg;

  // Multiply-divide unit operand widths: a * b / d
  localparam int DV_A_W   = 39;
  localparam int DV_B_W   = 33;
  localparam int DV_D_W   = 39;
  localparam int DV_P_W   = DV_A_W + DV_B_W;
  localparam int DV_CNT_W = 7;

  // Q16.16 fraction bits
  localparam int FRAC_W = 16;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_INTEG  = 2'd2,
    CMD_PREIMG = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_LEFT_X      = 2'd0;
  localparam logic [1:0] CFG_RIGHT_X     = 2'd1;
  localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_DIV
  } dv_state_t;

  typedef struct packed {
    logic [DV_A_W-1:0] a;
    logic [DV_B_W-1:0] b;
    logic [DV_D_W-1:0] d;
  } dv_req_t;

  typedef struct packed {
    logic              done;
    logic [DV_P_W-1:0] q;
    logic [DV_D_W-1:0] r;
    logic              round_up;
  } dv_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EV_START,
    ST_EV_ZERO,
    ST_EV_K,
    ST_EV_RDL,
    ST_EV_RDR,
    ST_EV_Q,
    ST_IN_START,
    ST_IN_ACC,
    ST_IN_DIV,
    ST_IN_Q,
    ST_PR_START,
    ST_PR_RD0,
    ST_PR_SEG,
    ST_PR_Q,
    ST_PR_EMIT,
    ST_PR_NEXT,
    ST_PR_END,
    ST_EMIT
  } st_t;

endpackage
`default_nettype wire

/* design/sfi_muldiv.sv */
`default_nettype none
module sfi_muldiv
  import sfi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire dv_req_t req,
  output dv_rsp_t      rsp
);

  dv_state_t           st_r, st_nxt;
  logic [DV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DV_P_W-1:0]   acc_r, acc_nxt;
  logic [DV_P_W-1:0]   mcand_r, mcand_nxt;
  logic [DV_B_W-1:0]   mplier_r, mplier_nxt;
  logic [DV_D_W-1:0]   d_r, d_nxt;
  logic [DV_D_W-1:0]   rem_r, rem_nxt;
  logic                done_r, done_nxt;
  logic [DV_D_W:0]     rem_sh;
  logic [DV_D_W:0]     rem_sub;
  logic                ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    d_r      <= d_nxt;
    rem_r    <= rem_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    d_nxt      = d_r;
    rem_nxt    = rem_r;
    done_nxt   = 1'b0;
    rem_sh     = {rem_r, acc_r[DV_P_W-1]};
    rem_sub    = rem_sh - {1'b0, d_r};
    ge         = (rem_sh >= {1'b0, d_r});
    case (st_r)
      DV_IDLE: begin
        if (start) begin
          acc_nxt    = '0;
          mcand_nxt  = DV_P_W'(req.a);
          mplier_nxt = req.b;
          d_nxt      = req.d;
          rem_nxt    = '0;
          cnt_nxt    = '0;
          st_nxt     = DV_MUL;
        end
      end
      DV_MUL: begin
        // shift-add multiply, one multiplier bit per cycle
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[DV_P_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[DV_B_W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == DV_CNT_W'(DV_B_W - 1)) begin
          cnt_nxt = '0;
          st_nxt  = DV_DIV;
        end
      end
      DV_DIV: begin
        // restoring divide, quotient bits shift into the product register
        rem_nxt = ge ? rem_sub[DV_D_W-1:0] : rem_sh[DV_D_W-1:0];
        acc_nxt = {acc_r[DV_P_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DV_CNT_W'(DV_P_W - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = DV_IDLE;
        end
      end
      default: st_nxt = DV_IDLE;
    endcase
  end

  assign rsp.done     = done_r;
  assign rsp.q        = acc_r;
  assign rsp.r        = rem_r;
  assign rsp.round_up = ({rem_r, 1'b0} >= {1'b0, d_r});

endmodule
`default_nettype wire

/* design/sfi_table.sv */
`default_nettype none
module sfi_table #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [31:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [31:0]       rdata
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [31:0]      rdata_r;
  logic             rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  // entries never written read as zero
  assign rdata = rvalid_r ? rdata_r : 32'd0;

endmodule
`default_nettype wire

/* design/sampled_function_interp_integrate_unit.sv */
`default_nettype none
// Piecewise-linear sample table with evaluate, integrate and preimage commands.
// Input stream: in_tuser carries the command, in_tdata sample_index and
// operand_value; one transaction per command, accepted only while the sequencer is idle.
// Output stream: out_tdata carries result_value, out_tuser the found flag and
// out_tlast the final result of a command. Writes produce no result.
// Configuration: cfg_we with cfg_addr 0 (left_x), 1 (right_x), 2 (point_count).
// Arithmetic: each scaling a * b / d goes through one shared shift-add
// multiply / restoring divide unit of 33 multiply steps, then 72 divide
// steps. Evaluate uses two unit operations (none for a zero span),
// integrate one pass over the n clamped points plus one operation,
// preimage one pass plus one operation per segment crossing y.
// A result waits in the output register while the receiver stalls; a preimage
// with several results then stalls its own walk until the register frees.
// Reset clears the sample table to zero (per-entry valid bits), restores the
// configuration defaults and drops any pending result.
module sampled_function_interp_integrate_unit
  import sfi_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  input  wire logic [39:0] in_tdata,   // sample_index[5:0], operand_value[37:6]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // result_value[31:0]
  output logic             out_tuser,  // found
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // configuration
  logic signed [31:0] left_r, right_r;
  logic        [6:0]  pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 32'sd0;
      right_r <= 32'sd65536;
      pc_r    <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LEFT_X:      left_r  <= cfg_wdata;
        CFG_RIGHT_X:     right_r <= cfg_wdata;
        CFG_POINT_COUNT: pc_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  st_t                state_r, state_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic        [6:0]  n_r, n_nxt;
  logic signed [32:0] span_r, span_nxt;
  logic        [6:0]  k_r, k_nxt;
  logic        [32:0] rem_r, rem_nxt;
  logic signed [31:0] yl_r, yl_nxt;
  logic               dyneg_r, dyneg_nxt;
  logic signed [39:0] acc_r, acc_nxt;
  logic signed [34:0] last_x_r, last_x_nxt;
  logic               last_v_r, last_v_nxt;
  logic signed [34:0] xn_r, xn_nxt;
  logic        [31:0] res_r, res_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_found_r, out_found_nxt;
  logic        out_last_r, out_last_nxt;
  logic        slot_free;

  // table port
  logic              tb_we;
  logic [ADDR_W-1:0] tb_waddr, tb_raddr;
  logic [31:0]       tb_rdata;

  // shared unit
  logic    dv_start;
  dv_req_t dv_req;
  dv_rsp_t dv_rsp;

  // working values
  logic        [1:0]        in_cmd;
  logic        [5:0]        in_idx;
  logic signed [31:0]       in_val;
  logic        [6:0]        n_clamp;
  logic        [6:0]        n_m1;
  logic        [31:0]       span_mag;
  logic signed [31:0]       lo_x, hi_x, xc;
  logic signed [32:0]       diff;
  logic        [32:0]       diff_mag;
  logic        [DV_P_W:0]   q_rnd;
  logic signed [32:0]       dy;
  logic        [32:0]       dy_mag;
  logic signed [39:0]       tval;
  logic        [39:0]       acc_mag;
  logic signed [31:0]       seg_lo, seg_hi;
  logic        [32:0]       dm, dyl_mag;
  logic signed [32:0]       dyl;
  logic        [6:0]        km1;
  logic        [39:0]       num, den;
  logic signed [34:0]       xcand;
  logic        [34:0]       off;

  sfi_table #(
    .DEPTH (MAX_POINTS),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (tb_we),
    .waddr(tb_waddr),
    .wdata(in_val),
    .raddr(tb_raddr),
    .rdata(tb_rdata)
  );

  sfi_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .req  (dv_req),
    .rsp  (dv_rsp)
  );

  assign in_cmd   = in_tuser;
  assign in_idx   = in_tdata[5:0];
  assign in_val   = in_tdata[37:6];
  assign tb_waddr = in_idx[ADDR_W-1:0];

  assign n_clamp  = (pc_r < 7'd2) ? 7'd2 :
                    ((pc_r > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : pc_r);
  assign n_m1     = n_r - 7'd1;
  assign km1      = k_r - 7'd1;
  assign span_mag = span_r[32] ? 32'(-span_r) : span_r[31:0];
  assign q_rnd    = {1'b0, dv_rsp.q} + (DV_P_W + 1)'(dv_rsp.round_up);
  assign off      = q_rnd[34:0];
  assign xcand    = span_r[32] ? ({{3{left_r[31]}}, left_r} - $signed(off))
                               : ({{3{left_r[31]}}, left_r} + $signed(off));

  assign in_tready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_v_r    <= last_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    n_r         <= n_nxt;
    span_r      <= span_nxt;
    k_r         <= k_nxt;
    rem_r       <= rem_nxt;
    yl_r        <= yl_nxt;
    dyneg_r     <= dyneg_nxt;
    acc_r       <= acc_nxt;
    last_x_r    <= last_x_nxt;
    xn_r        <= xn_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    n_nxt         = n_r;
    span_nxt      = span_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    yl_nxt        = yl_r;
    dyneg_nxt     = dyneg_r;
    acc_nxt       = acc_r;
    last_x_nxt    = last_x_r;
    last_v_nxt    = last_v_r;
    xn_nxt        = xn_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    tb_we         = 1'b0;
    tb_raddr      = '0;
    dv_start      = 1'b0;
    dv_req        = '0;

    lo_x     = span_r[32] ? right_r : left_r;
    hi_x     = span_r[32] ? left_r : right_r;
    xc       = (y_r < lo_x) ? lo_x : ((y_r > hi_x) ? hi_x : y_r);
    diff     = {xc[31], xc} - {left_r[31], left_r};
    diff_mag = diff[32] ? -diff : diff;
    dy       = {tb_rdata[31], tb_rdata} - {yl_r[31], yl_r};
    dy_mag   = dy[32] ? -dy : dy;
    tval     = {{8{tb_rdata[31]}}, tb_rdata};
    acc_mag  = acc_r[39] ? 40'(-acc_r) : acc_r;
    seg_lo   = ($signed(tb_rdata) < yl_r) ? $signed(tb_rdata) : yl_r;
    seg_hi   = ($signed(tb_rdata) < yl_r) ? yl_r : $signed(tb_rdata);
    dyl      = {y_r[31], y_r} - {yl_r[31], yl_r};
    dyl_mag  = dyl[32] ? -dyl : dyl;
    // flat segment: pretend slope one so it yields its left grid point
    if (dy_mag == 33'd0) begin
      dm  = 33'd1;
      num = 40'(km1);
    end else begin
      dm  = dy_mag;
      num = 40'(km1) * 40'(dy_mag) + 40'(dyl_mag);
    end
    den = 40'(n_m1) * 40'(dm);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          y_nxt    = in_val;
          n_nxt    = n_clamp;
          span_nxt = {right_r[31], right_r} - {left_r[31], left_r};
          case (cmd_t'(in_cmd))
            CMD_WRITE: tb_we = ({1'b0, in_idx} < 7'(MAX_POINTS));
            CMD_EVAL:  state_nxt = ST_EV_START;
            CMD_INTEG: state_nxt = ST_IN_START;
            default:   state_nxt = ST_PR_START;
          endcase
        end
      end

      ST_EV_START: begin
        if (span_r == 33'sd0) begin
          state_nxt = ST_EV_ZERO;
        end else begin
          dv_start  = 1'b1;
          dv_req.a  = DV_A_W'(diff_mag);
          dv_req.b  = DV_B_W'(n_m1);
          dv_req.d  = DV_D_W'(span_mag);
          state_nxt = ST_EV_K;
        end
      end
      ST_EV_ZERO: begin
        res_nxt   = tb_rdata;
        state_nxt = ST_EMIT;
      end
      ST_EV_K: begin
        if (dv_rsp.done) begin
          if (dv_rsp.q >= DV_P_W'(n_m1)) begin
            k_nxt   = n_r - 7'd2;
            rem_nxt = {1'b0, span_mag};
          end else begin
            k_nxt   = dv_rsp.q[6:0];
            rem_nxt = dv_rsp.r[32:0];
          end
          tb_raddr  = k_nxt[ADDR_W-1:0];
          state_nxt = ST_EV_RDL;
        end
      end
      ST_EV_RDL: begin
        yl_nxt    = tb_rdata;
        k_nxt     = k_r + 7'd1;
        tb_raddr  = k_nxt[ADDR_W-1:0];
        state_nxt = ST_EV_RDR;
      end
      ST_EV_RDR: begin
        dyneg_nxt = dy[32];
        dv_start  = 1'b1;
        dv_req.a  = DV_A_W'(dy_mag);
        dv_req.b  = rem_r;
        dv_req.d  = DV_D_W'(span_mag);
        state_nxt = ST_EV_Q;
      end
      ST_EV_Q: begin
        if (dv_rsp.done) begin
          res_nxt   = dyneg_r ? (yl_r - q_rnd[31:0]) : (yl_r + q_rnd[31:0]);
          state_nxt = ST_EMIT;
        end
      end

      ST_IN_START: begin
        k_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = ST_IN_ACC;
      end
      ST_IN_ACC: begin
        // end samples weigh once, inner samples twice
        if (k_r == 7'd0 || k_r == n_m1) begin
          acc_nxt = acc_r + tval;
        end else begin
          acc_nxt = acc_r + (tval <<< 1);
        end
        k_nxt    = k_r + 7'd1;
        tb_raddr = k_nxt[ADDR_W-1:0];
        if (k_r == n_m1) begin
          state_nxt = ST_IN_DIV;
        end
      end
      ST_IN_DIV: begin
        dv_start  = 1'b1;
        dv_req.a  = acc_mag[DV_A_W-1:0];
        dv_req.b  = DV_B_W'(span_mag);
        dv_req.d  = DV_D_W'(n_m1) << (FRAC_W + 1);
        state_nxt = ST_IN_Q;
      end
      ST_IN_Q: begin
        if (dv_rsp.done) begin
          if (acc_r[39] != span_r[32]) begin
            res_nxt = (q_rnd > (DV_P_W + 1)'(32'h8000_0000)) ? 32'h8000_0000
                                                              : -q_rnd[31:0];
          end else begin
            res_nxt = (q_rnd > (DV_P_W + 1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                              : q_rnd[31:0];
          end
          state_nxt = ST_EMIT;
        end
      end

      ST_PR_START: begin
        last_v_nxt = 1'b0;
        k_nxt      = 7'd1;
        state_nxt  = ST_PR_RD0;
      end
      ST_PR_RD0: begin
        yl_nxt    = tb_rdata;
        tb_raddr  = k_r[ADDR_W-1:0];
        state_nxt = ST_PR_SEG;
      end
      ST_PR_SEG: begin
        yl_nxt = tb_rdata;
        if (y_r >= seg_lo && y_r <= seg_hi) begin
          dv_start  = 1'b1;
          dv_req.a  = num[DV_A_W-1:0];
          dv_req.b  = DV_B_W'(span_mag);
          dv_req.d  = den[DV_D_W-1:0];
          state_nxt = ST_PR_Q;
        end else begin
          state_nxt = ST_PR_NEXT;
        end
      end
      ST_PR_Q: begin
        if (dv_rsp.done) begin
          if (!last_v_r || xcand != last_x_r) begin
            if (last_v_r) begin
              xn_nxt    = xcand;
              state_nxt = ST_PR_EMIT;
            end else begin
              last_x_nxt = xcand;
              last_v_nxt = 1'b1;
              state_nxt  = ST_PR_NEXT;
            end
          end else begin
            state_nxt = ST_PR_NEXT;
          end
        end
      end
      ST_PR_EMIT: begin
        // release the held crossing, now known not to be the final one
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = last_x_r[31:0];
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          last_x_nxt    = xn_r;
          state_nxt     = ST_PR_NEXT;
        end
      end
      ST_PR_NEXT: begin
        if (k_r == n_m1) begin
          state_nxt = ST_PR_END;
        end else begin
          k_nxt     = k_r + 7'd1;
          tb_raddr  = k_nxt[ADDR_W-1:0];
          state_nxt = ST_PR_SEG;
        end
      end
      ST_PR_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = last_v_r ? last_x_r[31:0] : 32'd0;
          out_found_nxt = last_v_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_found_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dv_rsp.done |-> (state_r != ST_IDLE))
    else $error("muldiv result with sequencer idle");

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("not-found result must end its command");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !dv_rsp.done)
    else $error("transaction accepted while unit finishing");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import sfi_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        found;
    logic        last;
  } interp_result_t;

  class interp_scoreboard;
    longint         samples[64];
    longint         left_x;
    longint         right_x;
    bit [6:0]       point_count;
    interp_result_t expected[$];
    int             errors;
    int             mismatches;

    function new();
      foreach (samples[i]) samples[i] = 0;
      left_x      = 0;
      right_x     = 65536;
      point_count = 64;
    endfunction

    function void set_reg(logic [1:0] addr, logic [31:0] data);
      if (addr == CFG_LEFT_X) left_x = longint'($signed(data));
      else if (addr == CFG_RIGHT_X) right_x = longint'($signed(data));
      else if (addr == CFG_POINT_COUNT) point_count = data[6:0];
    endfunction

    function int points_in_use();
      if (point_count < 2) return 2;
      if (point_count > 64) return 64;
      return point_count;
    endfunction

    function bit [63:0] mag(longint s);
      return s < 0 ? 64'(-s) : 64'(s);
    endfunction

    // rounded a*b/d, ties away from zero
    function bit [63:0] scale_round(bit [63:0] a, bit [63:0] b, bit [63:0] d);
      bit [127:0] prod;
      bit [127:0] quo;
      bit [127:0] rem;
      prod = {64'd0, a} * {64'd0, b};
      quo  = prod / {64'd0, d};
      rem  = prod % {64'd0, d};
      if (rem >= {64'd0, d} - rem) quo++;
      return quo[63:0];
    endfunction

    function longint eval_at(longint x, int n);
      longint    span;
      longint    lo;
      longint    hi;
      longint    yl;
      longint    dy;
      bit [63:0] b;
      bit [63:0] a;
      bit [63:0] k;
      bit [63:0] rem;
      bit [63:0] q;
      span = right_x - left_x;
      lo   = span >= 0 ? left_x : right_x;
      hi   = span >= 0 ? right_x : left_x;
      if (span == 0) return samples[0];
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      b = mag(span);
      a = mag(x - left_x) * 64'(n - 1);
      k = a / b;
      if (k > 64'(n - 2)) k = 64'(n - 2);
      rem = a - k * b;
      yl  = samples[k];
      dy  = samples[k + 1] - yl;
      // the product stays within 64 bits, so it never wraps
      q = (mag(dy) * rem + b / 2) / b;
      return dy < 0 ? yl - longint'(q) : yl + longint'(q);
    endfunction

    function longint trapezoid(int n);
      longint    s2;
      longint    span;
      bit [63:0] q;
      bit        neg;
      s2   = samples[0] + samples[n - 1];
      span = right_x - left_x;
      for (int i = 1; i < n - 1; i++) s2 += 2 * samples[i];
      neg = (s2 < 0) != (span < 0);
      q   = scale_round(mag(s2), mag(span), 64'(n - 1) * 64'd131072);
      if (neg) return q > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(q);
      return q > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(q);
    endfunction

    function void push(longint v, bit found, bit last);
      interp_result_t r;
      r.value = v[31:0];
      r.found = found;
      r.last  = last;
      expected.push_back(r);
    endfunction

    function void crossings(longint y, int n);
      longint    span;
      longint    yl;
      longint    yr;
      longint    lo;
      longint    hi;
      longint    x;
      longint    prev_x;
      bit        have_prev;
      bit [63:0] dm;
      bit [63:0] num;
      bit [63:0] off;
      int        cnt;
      span      = right_x - left_x;
      have_prev = 0;
      prev_x    = 0;
      cnt       = 0;
      for (int k = 1; k < n; k++) begin
        yl = samples[k - 1];
        yr = samples[k];
        lo = yl < yr ? yl : yr;
        hi = yl < yr ? yr : yl;
        if (y < lo || y > hi) continue;
        dm = mag(yr - yl);
        // flat segment: take its left grid point
        if (dm == 0) begin
          dm  = 1;
          num = 64'(k - 1);
        end else begin
          num = 64'(k - 1) * dm + mag(y - yl);
        end
        off = scale_round(num, mag(span), 64'(n - 1) * dm);
        x   = span < 0 ? left_x - longint'(off) : left_x + longint'(off);
        // drop a repeat of the x just emitted
        if (!have_prev || x != prev_x) begin
          prev_x    = x;
          have_prev = 1;
          push(x, 1, 0);
          cnt++;
        end
      end
      if (cnt == 0) push(0, 0, 1);
      else expected[$].last = 1;
    endfunction

    function void note_command(cmd_t cmd, logic [5:0] idx, logic [31:0] operand);
      longint v;
      int     n;
      v = longint'($signed(operand));
      n = points_in_use();
      case (cmd)
        CMD_WRITE:  samples[idx] = v;
        CMD_EVAL:   push(eval_at(v, n), 1, 1);
        CMD_INTEG:  push(trapezoid(n), 1, 1);
        CMD_PREIMG: crossings(v, n);
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] value, logic found, logic last);
      interp_result_t r;
      if (expected.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result: value %h found %b last %b", value, found, last);
        return;
      end
      r = expected.pop_front();
      if (value !== r.value || found !== r.found || last !== r.last) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                   r.value, r.found, r.last, value, found, last);
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  interp_scoreboard sb = new();
  int               sender_idle;
  int               recv_idle;
  bit               hold_go;
  int               hold_left;

  sampled_function_interp_integrate_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      hold_left  = 0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if (hold_go) begin
        hold_go   = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 0;
      end else begin
        out_tready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  task automatic send(cmd_t cmd, logic [5:0] idx, logic [31:0] operand);
    if ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, operand, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, idx, operand);
  endtask

  // hold input until every expected transaction is out and the block is idle
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_domain(logic [31:0] lx, logic [31:0] rx, logic [6:0] cnt);
    cfg_we    <= 1;
    cfg_addr  <= CFG_LEFT_X;
    cfg_wdata <= lx;
    @(posedge clk);
    cfg_addr  <= CFG_RIGHT_X;
    cfg_wdata <= rx;
    @(posedge clk);
    cfg_addr  <= CFG_POINT_COUNT;
    cfg_wdata <= {25'd0, cnt};
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(CFG_LEFT_X, lx);
    sb.set_reg(CFG_RIGHT_X, rx);
    sb.set_reg(CFG_POINT_COUNT, {25'd0, cnt});
  endtask

  function automatic logic [31:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'($signed($urandom_range(8)) - 4) << 16;
    if (r < 80) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  initial begin
    logic [31:0] lx;
    logic [31:0] rx;
    logic [6:0]  cnt;
    int          n;
    int          r;
    rst_n       = 0;
    in_tvalid   = 0;
    in_tuser    = '0;
    in_tdata    = '0;
    cfg_we      = 0;
    cfg_addr    = CFG_LEFT_X;
    cfg_wdata   = '0;
    hold_go     = 0;
    sender_idle = 0;
    recv_idle   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // defaults after reset
    send(CMD_EVAL, 6'd0, 32'h0000_8000);
    send(CMD_PREIMG, 6'd0, 32'd0);
    drain();
    set_domain(32'd0, 32'h0008_0000, 7'd9);
    send(CMD_WRITE, 6'd0, 32'h0000_0000);
    send(CMD_WRITE, 6'd1, 32'h0002_0000);
    send(CMD_WRITE, 6'd2, 32'h0002_0000);
    send(CMD_WRITE, 6'd3, 32'hFFFF_0000);
    send(CMD_WRITE, 6'd4, 32'h8000_0000);
    send(CMD_WRITE, 6'd5, 32'h7FFF_FFFF);
    send(CMD_WRITE, 6'd6, 32'h0001_0000);
    send(CMD_WRITE, 6'd7, 32'h0001_0000);
    send(CMD_WRITE, 6'd8, 32'h0000_0000);
    send(CMD_WRITE, 6'd63, 32'hA5A5_5A5A);
    send(CMD_EVAL, 6'd63, 32'h8000_0000);
    send(CMD_EVAL, 6'd0, 32'h7FFF_FFFF);
    send(CMD_EVAL, 6'd0, 32'h0001_8000);
    send(CMD_EVAL, 6'd0, 32'h0004_4000);
    send(CMD_INTEG, 6'd0, 32'd0);
    hold_go = 1;
    send(CMD_PREIMG, 6'd0, 32'h0002_0000);
    send(CMD_PREIMG, 6'd0, 32'h0001_0000);
    send(CMD_PREIMG, 6'd0, 32'd0);
    send(CMD_PREIMG, 6'd0, 32'h7FFF_FFFF);
    drain();

    for (int p = 0; p < 9; p++) begin
      sender_idle = p < 3 ? 21 : (p < 6 ? 46 : 0);
      recv_idle   = p < 3 ? 46 : (p < 6 ? 21 : 0);
      r   = p % 5;
      lx  = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(8)) - 4) << 16;
      rx  = lx + ($urandom_range(40) << 14);
      cnt = 7'($urandom_range(2, 12));
      case (r)
        1: rx = lx - ($urandom_range(1, 40) << 14);
        2: rx = lx;
        3: begin
          lx  = 32'h8000_0000;
          rx  = 32'h7FFF_FFFF;
          cnt = 7'd64;
        end
        4: cnt = $urandom_range(1) ? 7'($urandom_range(1)) : 7'($urandom_range(65, 127));
        default: ;
      endcase
      if (p == 8) begin
        lx = 32'h7FFF_FFFF;
        rx = 32'h8000_0000;
      end
      set_domain(lx, rx, cnt);
      n = cnt < 2 ? 2 : (cnt > 64 ? 64 : cnt);
      for (int i = 0; i < n && i < 12; i++) send(CMD_WRITE, 6'(i), pick_level());
      for (int i = 0; i < 10; i++) begin
        r = $urandom_range(99);
        if (r < 15) send(CMD_WRITE, 6'($urandom_range(63)), pick_level());
        else if (r < 45) send(CMD_EVAL, 6'($urandom_range(63)),
                              $urandom_range(1) ? $urandom : lx + ($urandom_range(64) << 12));
        else if (r < 55) send(CMD_INTEG, 6'($urandom_range(63)), $urandom);
        else send(CMD_PREIMG, 6'($urandom_range(63)),
                  r < 90 ? pick_level() : pick_level() + 32'h8000);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sampled_function_interp_integrate_unit.f */
design/sfi_pkg.sv
design/sfi_muldiv.sv
design/sfi_table.sv
design/sampled_function_interp_integrate_unit.sv
verif/tb_top.sv
